### rtl/core/mcct_pkg.sv
// ----------------------------------------------------------------------------
// mcct_pkg
// Shared constants and types of the minimum coin change table.
// ----------------------------------------------------------------------------
`default_nettype none

package mcct_pkg;

   // Largest amount the table covers; the table has one entry per amount.
   localparam int MAX_AMOUNT  = 1023;
   localparam int TABLE_DEPTH = MAX_AMOUNT + 1;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);

   // Field widths fixed by the interface.
   localparam int AMT_W = 10;
   localparam int CNT_W = 11;

   // Table value that marks an amount as not yet reachable.
   localparam logic [CNT_W-1:0] UNREACHABLE = {CNT_W{1'b1}};

   // Depth of the queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One classified coin as it travels from the front to the back.
   typedef struct packed {
      logic [AMT_W-1:0] coin;
      logic [AMT_W-1:0] target;
      logic             active;
      logic             last;
   } coin_job_type;

   // Status that the back reports to the front.
   typedef struct packed {
      logic clearing;
   } back_status_type;

endpackage

`default_nettype wire

### rtl/core/min_coin_change_table.sv
// Each coin walks the table from its own value up to the target, one amount a
// cycle through the two-read, one-write table memory. A coin of 0 or above
// the target is not walked. The last coin reads the target entry into the
// result beat and is followed by a clear of the whole table.
// After reset a clearing pass runs and no coin is taken until it ends; the
// configuration write port is always ready.
// ----------------------------------------------------------------------------
// min_coin_change_table
// Fewest coins that make a configured target, built one coin kind per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module min_coin_change_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [mcct_pkg::AMT_W-1:0]  req_coin_value,
   input  wire logic                        req_last_coin,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic                             rsp_reachable,
   output logic [mcct_pkg::AMT_W-1:0]       rsp_min_coins,
   input  wire logic                        csr_valid,
   output logic                             csr_ready,
   input  wire logic [mcct_pkg::AMT_W-1:0]  csr_target_amount
);

   logic                      job_valid;
   logic                      job_pop;
   mcct_pkg::coin_job_type    job;
   mcct_pkg::back_status_type back_status;

   mcct_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_coin_value    (req_coin_value),
      .req_last_coin     (req_last_coin),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_target_amount (csr_target_amount),
      .back_status       (back_status),
      .job_valid         (job_valid),
      .job               (job),
      .job_pop           (job_pop)
   );

   mcct_back u_back (
      .clock         (clock),
      .reset         (reset),
      .job_valid     (job_valid),
      .job           (job),
      .job_pop       (job_pop),
      .back_status   (back_status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_reachable (rsp_reachable),
      .rsp_min_coins (rsp_min_coins)
   );

endmodule

`default_nettype wire

### rtl/core/mcct_front.sv
// ----------------------------------------------------------------------------
// mcct_front
// Accepts coins, holds the target register, classifies each coin against
// the target in force and queues it for the back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic [mcct_pkg::AMT_W-1:0]     req_coin_value,
   input  wire logic                           req_last_coin,
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [mcct_pkg::AMT_W-1:0]     csr_target_amount,
   input  wire mcct_pkg::back_status_type      back_status,
   output logic                                job_valid,
   output mcct_pkg::coin_job_type              job,
   input  wire logic                           job_pop
);

   logic [mcct_pkg::AMT_W-1:0]  target_ff;
   logic [mcct_pkg::AMT_W-1:0]  eff_target;
   mcct_pkg::coin_job_type      job_in;
   mcct_pkg::coin_job_type      queue_ff [mcct_pkg::QUEUE_DEPTH];
   logic [mcct_pkg::QPTR_W-1:0] wr_ptr_ff;
   logic [mcct_pkg::QPTR_W-1:0] rd_ptr_ff;
   logic [mcct_pkg::QCNT_W-1:0] count_ff;
   logic [mcct_pkg::QCNT_W-1:0] count_in;
   logic                        push;
   logic                        pop;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
      end else if (csr_valid) begin
         target_ff <= csr_target_amount;
      end
   end

   // Targets beyond the table saturate to its last entry.
   always_comb begin
      if (target_ff > mcct_pkg::AMT_W'(mcct_pkg::MAX_AMOUNT)) begin
         eff_target = mcct_pkg::AMT_W'(mcct_pkg::MAX_AMOUNT);
      end else begin
         eff_target = target_ff;
      end
      job_in.coin   = req_coin_value;
      job_in.target = eff_target;
      job_in.active = (req_coin_value != '0) && (req_coin_value <= eff_target);
      job_in.last   = req_last_coin;
   end

   assign req_stall = (count_ff == mcct_pkg::QCNT_W'(mcct_pkg::QUEUE_DEPTH))
                      || back_status.clearing;
   assign push      = req_valid && !req_stall;
   assign pop       = job_pop && job_valid;
   assign job_valid = (count_ff != '0);
   assign job       = queue_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/mcct_back.sv
// ----------------------------------------------------------------------------
// mcct_back
// Walks the count table for each queued coin within the target, one amount
// per cycle, reads the target entry at the end of a job and clears the table afterward.
// ----------------------------------------------------------------------------
`default_nettype none

module mcct_back (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           job_valid,
   input  wire mcct_pkg::coin_job_type         job,
   output logic                                job_pop,
   output mcct_pkg::back_status_type           back_status,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic                                rsp_reachable,
   output logic [mcct_pkg::AMT_W-1:0]          rsp_min_coins
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_WALK   = 4'b0010,
      ST_RESULT = 4'b0100,
      ST_CLEAR  = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;

   logic [mcct_pkg::AMT_W-1:0]  j_ff, j_in;
   logic [mcct_pkg::AMT_W-1:0]  end_ff, end_in;
   logic [mcct_pkg::AMT_W-1:0]  coin_ff, coin_in;
   logic                        last_ff, last_in;
   logic [mcct_pkg::ADDR_W-1:0] clr_ff, clr_in;

   logic                        issue_walk;
   logic                        issue_res;
   logic [mcct_pkg::AMT_W-1:0]  base_amt;
   logic [mcct_pkg::ADDR_W-1:0] rd_a_addr;
   logic [mcct_pkg::ADDR_W-1:0] rd_b_addr;

   logic [mcct_pkg::CNT_W-1:0]  table_mem [mcct_pkg::TABLE_DEPTH];
   logic [mcct_pkg::CNT_W-1:0]  rd_a_ff;
   logic [mcct_pkg::CNT_W-1:0]  rd_b_ff;

   logic                        s1_walk_ff;
   logic                        s1_res_ff;
   logic [mcct_pkg::ADDR_W-1:0] s1_a_addr_ff;
   logic [mcct_pkg::ADDR_W-1:0] s1_b_addr_ff;

   logic                        fwd_valid_ff;
   logic [mcct_pkg::ADDR_W-1:0] fwd_addr_ff;
   logic [mcct_pkg::CNT_W-1:0]  fwd_data_ff;

   logic [mcct_pkg::CNT_W-1:0]  a_val;
   logic [mcct_pkg::CNT_W-1:0]  b_val;
   logic [mcct_pkg::CNT_W-1:0]  cand;
   logic [mcct_pkg::CNT_W-1:0]  new_val;

   logic                        mem_we;
   logic [mcct_pkg::ADDR_W-1:0] mem_waddr;
   logic [mcct_pkg::CNT_W-1:0]  mem_wdata;

   logic                        rsp_valid_ff;
   logic                        rsp_reachable_ff;
   logic [mcct_pkg::AMT_W-1:0]  rsp_min_coins_ff;

   // ---------------- sequencer ----------------
   assign issue_walk = (state_ff == ST_WALK);
   assign issue_res  = (state_ff == ST_RESULT) && !rsp_valid_ff;
   assign job_pop    = (state_ff == ST_IDLE) && job_valid;
   assign back_status.clearing = (state_ff == ST_CLEAR);

   always_comb begin
      state_in = state_ff;
      j_in     = j_ff;
      end_in   = end_ff;
      coin_in  = coin_ff;
      last_in  = last_ff;
      clr_in   = clr_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid) begin
               coin_in = job.coin;
               j_in    = job.coin;
               end_in  = job.target;
               last_in = job.last;
               if (job.active) begin
                  state_in = ST_WALK;
               end else if (job.last) begin
                  state_in = ST_RESULT;
               end
            end
         end
         ST_WALK: begin
            if (j_ff == end_ff) begin
               state_in = last_ff ? ST_RESULT : ST_IDLE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff) begin
               state_in = ST_CLEAR;
               clr_in   = '0;
            end
         end
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == mcct_pkg::ADDR_W'(mcct_pkg::TABLE_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
   end

   always_ff @(posedge clock) begin
      j_ff    <= j_in;
      end_ff  <= end_in;
      coin_ff <= coin_in;
      last_ff <= last_in;
   end

   // ---------------- table reads ----------------
   // Port A fetches the smaller amount that the coin builds on, or the target
   // entry for a result; port B fetches the amount being improved.
   assign base_amt  = j_ff - coin_ff;
   assign rd_a_addr = issue_res ? mcct_pkg::ADDR_W'(end_ff)
                                : mcct_pkg::ADDR_W'(base_amt);
   assign rd_b_addr = mcct_pkg::ADDR_W'(j_ff);

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= table_mem[rd_a_addr];
      rd_b_ff <= table_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_walk_ff <= 1'b0;
         s1_res_ff  <= 1'b0;
      end else begin
         s1_walk_ff <= issue_walk;
         s1_res_ff  <= issue_res;
      end
   end

   always_ff @(posedge clock) begin
      s1_a_addr_ff <= rd_a_addr;
      s1_b_addr_ff <= rd_b_addr;
   end

   // ---------------- update and write ----------------
   // A write that lands on the same edge as a read is not seen by that read,
   // so the last write is kept and forwarded. With a coin of one this is the
   // entry written in the previous cycle.
   always_comb begin
      if (fwd_valid_ff && (fwd_addr_ff == s1_a_addr_ff)) begin
         a_val = fwd_data_ff;
      end else begin
         a_val = rd_a_ff;
      end
      if (fwd_valid_ff && (fwd_addr_ff == s1_b_addr_ff)) begin
         b_val = fwd_data_ff;
      end else begin
         b_val = rd_b_ff;
      end
      cand = a_val + 1'b1;
      if ((a_val != mcct_pkg::UNREACHABLE) && (cand < b_val)) begin
         new_val = cand;
      end else begin
         new_val = b_val;
      end
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         mem_we    = 1'b1;
         mem_waddr = clr_ff;
         mem_wdata = (clr_ff == '0) ? '0 : mcct_pkg::UNREACHABLE;
      end else begin
         mem_we    = s1_walk_ff;
         mem_waddr = s1_b_addr_ff;
         mem_wdata = new_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (mem_we) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         fwd_addr_ff <= mem_waddr;
         fwd_data_ff <= mem_wdata;
      end
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_res_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_res_ff) begin
         rsp_reachable_ff <= (a_val != mcct_pkg::UNREACHABLE);
         rsp_min_coins_ff <= (a_val != mcct_pkg::UNREACHABLE)
                             ? mcct_pkg::AMT_W'(a_val) : '0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_reachable = rsp_reachable_ff;
   assign rsp_min_coins = rsp_min_coins_ff;

   // ---------------- assertions ----------------
   // The clearing pass and a coin update never share the write port.
   a_no_write_clash: assert property (@(posedge clock) disable iff (reset)
      !((state_ff == ST_CLEAR) && s1_walk_ff))
      else $error("clearing pass collides with a table update");

   // A result is read only into an empty output register.
   a_rsp_free: assert property (@(posedge clock) disable iff (reset)
      s1_res_ff |-> !rsp_valid_ff)
      else $error("result overwrites a beat still waiting");

   // The walk never runs past the target of its coin.
   a_walk_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK) |-> ((j_ff <= end_ff) && (j_ff >= coin_ff)))
      else $error("walk index outside the coin range");

   // A job never starts while the table is being cleared.
   a_no_pop_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |=> !$past(job_pop))
      else $error("job taken during the clearing pass");

endmodule

`default_nettype wire

### verif/min_coin_change_table_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// min_coin_change_table_tb
// Checks the fewest-coins result of every job against a behavioral table kept
// in the bench or a typed answer. A short table of directed beats covers the
// corner cases. Random jobs follow under several target settings and idle
// patterns, with one long result hold-off and one sender pause.
// ----------------------------------------------------------------------------

module min_coin_change_table_tb;

   localparam int SETTLE_CYCLES = 6000;
   localparam int END_CYCLES    = 2200;
   localparam int LONG_HOLD     = 3000;
   localparam int RUN_LIMIT_NS  = 10000000;
   localparam int NUM_ROWS      = 24;

   typedef struct packed {
      logic                       reachable;
      logic [mcct_pkg::AMT_W-1:0] min_coins;
   } coin_answer_type;

   typedef enum logic {ROW_COIN, ROW_TARGET} row_kind_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [mcct_pkg::AMT_W-1:0] value;
      logic                       is_last;
      logic                       typed;
      logic                       exp_reach;
      logic [mcct_pkg::AMT_W-1:0] exp_count;
   } stim_row_type;

   // Rows with typed set carry the answer that can be read off directly;
   // the others are checked against the bench's own table.
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{ROW_TARGET, 10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd0,    1'b1, 1'b1, 1'b1, 10'd0},
      '{ROW_COIN,   10'd1023, 1'b1, 1'b1, 1'b1, 10'd0},
      '{ROW_TARGET, 10'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd1,    1'b1, 1'b1, 1'b1, 10'd1023},
      '{ROW_COIN,   10'd1023, 1'b1, 1'b1, 1'b1, 10'd1},
      '{ROW_COIN,   10'd0,    1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_COIN,   10'd1022, 1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_TARGET, 10'd10,   1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd0,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd11,   1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd3,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd4,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd1023, 1'b1, 1'b1, 1'b0, 10'd0},
      '{ROW_COIN,   10'd7,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_TARGET, 10'd20,   1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd13,   1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd3,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_TARGET, 10'd6,    1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd5,    1'b1, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd6,    1'b1, 1'b1, 1'b1, 10'd1},
      '{ROW_TARGET, 10'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd512,  1'b0, 1'b0, 1'b0, 10'd0},
      '{ROW_COIN,   10'd511,  1'b1, 1'b0, 1'b0, 10'd0}
   };

   logic                       clock;
   logic                       reset;
   logic                       req_valid;
   logic                       req_stall;
   logic [mcct_pkg::AMT_W-1:0] req_coin_value;
   logic                       req_last_coin;
   logic                       rsp_valid;
   logic                       rsp_stall;
   logic                       rsp_reachable;
   logic [mcct_pkg::AMT_W-1:0] rsp_min_coins;
   logic                       csr_valid;
   logic                       csr_ready;
   logic [mcct_pkg::AMT_W-1:0] csr_target_amount;

   logic [mcct_pkg::CNT_W-1:0] best_counts [0:mcct_pkg::MAX_AMOUNT];
   logic [mcct_pkg::AMT_W-1:0] job_target;
   coin_answer_type            pending_answers [$];
   int                         error_count;
   int                         send_idle_pct;
   int                         recv_idle_pct;
   int                         long_hold_cycles;

   min_coin_change_table u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_coin_value    (req_coin_value),
      .req_last_coin     (req_last_coin),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reachable     (rsp_reachable),
      .rsp_min_coins     (rsp_min_coins),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_target_amount (csr_target_amount)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("CHECK FAILED");
      $finish;
   end

   task automatic clear_counts();
      best_counts[0] = '0;
      for (int amt = 1; amt <= mcct_pkg::MAX_AMOUNT; amt++) begin
         best_counts[amt] = mcct_pkg::UNREACHABLE;
      end
   endtask

   // Applies one coin to the table, walking amounts upward so the coin may be
   // reused; the last coin of a job reads the target entry and clears the table.
   task automatic fold_coin(input logic [mcct_pkg::AMT_W-1:0] coin,
                            input logic is_last,
                            output bit produced, output coin_answer_type answer);
      int                         limit;
      logic [mcct_pkg::CNT_W-1:0] prev;
      limit = int'(job_target);
      if (limit > mcct_pkg::MAX_AMOUNT) limit = mcct_pkg::MAX_AMOUNT;
      produced = 1'b0;
      answer = '0;
      if (coin != 0 && int'(coin) <= limit) begin
         for (int amt = int'(coin); amt <= limit; amt++) begin
            prev = best_counts[amt - int'(coin)];
            if (prev != mcct_pkg::UNREACHABLE && prev + 1'b1 < best_counts[amt])
               best_counts[amt] = prev + 1'b1;
         end
      end
      if (is_last) begin
         produced = 1'b1;
         if (best_counts[limit] != mcct_pkg::UNREACHABLE) begin
            answer.reachable = 1'b1;
            answer.min_coins = best_counts[limit][mcct_pkg::AMT_W-1:0];
         end
         clear_counts();
      end
   endtask

   // Starts and ends at a falling edge; valid stays high after the beat.
   task automatic offer_coin(input logic [mcct_pkg::AMT_W-1:0] coin,
                             input logic is_last,
                             input bit typed, input coin_answer_type typed_answer);
      bit              produced;
      coin_answer_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_coin_value <= coin;
      req_last_coin  <= is_last;
      do @(posedge clock); while (req_stall);
      fold_coin(coin, is_last, produced, predicted);
      if (produced) pending_answers.push_back(typed ? typed_answer : predicted);
      @(negedge clock);
   endtask

   task automatic drain_answers();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // A coin that yields no result may still be walking the table, so the
   // write waits out the longest walk plus the table clear.
   task automatic write_target(input logic [mcct_pkg::AMT_W-1:0] value);
      drain_answers();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid         <= 1'b1;
      csr_target_amount <= value;
      do @(posedge clock); while (!csr_ready);
      job_target = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly coins that touch the table, with some zero or oversized noise.
   task automatic stream_coins(input int count);
      int                         done;
      int                         top;
      logic [mcct_pkg::AMT_W-1:0] coin;
      logic                       is_last;
      done = 0;
      top  = int'(job_target);
      while (done < count) begin
         if (top > 0 && $urandom_range(0, 99) < 85)
            coin = mcct_pkg::AMT_W'($urandom_range(1, top));
         else
            coin = mcct_pkg::AMT_W'($urandom_range(0, mcct_pkg::MAX_AMOUNT));
         is_last = ($urandom_range(0, 4) == 0);
         done++;
         offer_coin(coin, is_last, 1'b0, '0);
      end
   endtask

   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            long_hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      coin_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: result beat with none expected, reachable=%0b min_coins=%0d",
                     $time, rsp_reachable, rsp_min_coins);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_reachable !== want.reachable) begin
               $display("%0t: reachable expected %0b actual %0b",
                        $time, want.reachable, rsp_reachable);
               error_count++;
            end
            if (rsp_min_coins !== want.min_coins) begin
               $display("%0t: min_coins expected %0d actual %0d",
                        $time, want.min_coins, rsp_min_coins);
               error_count++;
            end
         end
      end
   end

   initial begin
      coin_answer_type typed_answer;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_coin_value    = '0;
      req_last_coin     = 1'b0;
      csr_valid         = 1'b0;
      csr_target_amount = '0;
      error_count       = 0;
      long_hold_cycles  = 0;
      send_idle_pct     = 35;
      recv_idle_pct     = 81;
      job_target        = '0;
      clear_counts();
      repeat (5) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (DIRECTED_ROWS[i]) begin
         if (DIRECTED_ROWS[i].kind == ROW_TARGET) begin
            write_target(DIRECTED_ROWS[i].value);
         end else begin
            typed_answer = {DIRECTED_ROWS[i].exp_reach, DIRECTED_ROWS[i].exp_count};
            offer_coin(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].is_last,
                       DIRECTED_ROWS[i].typed, typed_answer);
         end
      end

      write_target(10'd37);
      stream_coins(140);
      write_target(10'd1023);
      stream_coins(10);

      send_idle_pct = 81;
      recv_idle_pct = 35;
      write_target(10'd0);
      stream_coins(20);
      write_target(mcct_pkg::AMT_W'($urandom_range(1, 63)));
      stream_coins(70);
      // The sender holds back until every result of the job stream is in.
      drain_answers();
      stream_coins(70);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_target(mcct_pkg::AMT_W'($urandom_range(100, 700)));
      stream_coins(15);
      write_target(mcct_pkg::AMT_W'($urandom_range(1, 24)));
      // A long hold on the result side lets the block back up into its input.
      @(posedge clock);
      long_hold_cycles = LONG_HOLD;
      @(negedge clock);
      stream_coins(175);

      drain_answers();
      repeat (END_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
